[rtl/voice_allocator_adsr_macros.svh]
// Assertion macros for the voice allocator checker.
// No dependencies.
`ifndef VOICE_ALLOCATOR_ADSR_MACROS_SVH
`define VOICE_ALLOCATOR_ADSR_MACROS_SVH
`define VA_ASSERT_IMPL(lbl, clk_s, rst_s, a, c) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |-> (c)) \
        else $error("assertion failed");
`define VA_ASSERT_NEXT(lbl, clk_s, rst_s, a, c) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (a) |=> (c)) \
        else $error("assertion failed");
`endif

[rtl/vaa_pkg.sv]
// Shared types and constants of the voice allocator.
// No dependencies.
package vaa_pkg;
    localparam logic [16:0] FULL = 17'd65536;

    typedef enum logic [2:0] {
        CMD_NOTE_ON = 3'd0, CMD_NOTE_OFF = 3'd1, CMD_ALL_OFF = 3'd2,
        CMD_PANIC = 3'd3, CMD_TICK = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0, ST_ATTACK = 3'd1, ST_DECAY = 3'd2,
        ST_SUSTAIN = 3'd3, ST_RELEASE = 3'd4
    } stage_t;

    localparam logic [1:0] KIND_NOTE_ON = 2'd0;
    localparam logic [1:0] KIND_REPORT  = 2'd1;
    localparam logic [1:0] KIND_ACK     = 2'd2;

    localparam logic [2:0] REG_LIMIT   = 3'd0;
    localparam logic [2:0] REG_STEAL   = 3'd1;
    localparam logic [2:0] REG_SAMPLE  = 3'd2;
    localparam logic [2:0] REG_SUSTAIN = 3'd3;
    localparam logic [2:0] REG_ATTACK  = 3'd4;
    localparam logic [2:0] REG_DECAY   = 3'd5;
    localparam logic [2:0] REG_RELEASE = 3'd6;

    localparam logic [1:0] STEAL_OLDEST  = 2'd1;
    localparam logic [1:0] STEAL_QUIETEST = 2'd2;

    // datapath operation codes
    typedef enum logic [2:0] {
        OP_NONE, OP_SCAN, OP_WRITE_ON, OP_RELEASE, OP_PANIC, OP_TICK
    } op_t;

    typedef struct packed {
        op_t        op;
        logic       clear;   // start of a scan: reset best/found
    } dp_cmd_t;

    typedef struct packed {
        logic       idle_hit;   // current voice is idle
        logic       note_hit;   // active, non-releasing, note matches
    } dp_stat_t;

    function automatic logic [16:0] sat_full(input logic [16:0] v);
        return (v > FULL) ? FULL : v;
    endfunction

    function automatic logic [16:0] step_of(input logic [16:0] v);
        return (v == 17'd0) ? 17'd1 : sat_full(v);
    endfunction
endpackage

[rtl/vaa_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module vaa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[rtl/vaa_ctrl.sv]
// Sequencer of the voice allocator: walks voices for each command.
// Depends on vaa_pkg.
module vaa_ctrl import vaa_pkg::*; #(
    parameter int IW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [2:0]    cmd,
    input  logic [IW:0]   limit,
    input  logic [IW:0]   all_count,
    input  logic          sample_present,
    input  logic [1:0]    steal_mode,
    input  dp_stat_t      stat,
    input  logic          out_free,
    output logic          busy,
    output dp_cmd_t       dcmd,
    output logic [IW-1:0] vidx,
    output logic          emit,
    output logic [1:0]    emit_kind,
    output logic          emit_last,
    output logic          use_best
);
    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_EVAL, S_WR, S_OUT
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    cmd_reg, cmd_next;
    logic [IW:0]   idx_reg, idx_next;
    logic          pass_reg, pass_next; // note on: 0 idle scan, 1 steal scan
    logic [IW:0]   end_cnt;
    logic          at_end;

    assign end_cnt = (cmd_reg == CMD_ALL_OFF || cmd_reg == CMD_PANIC) ? all_count : limit;
    assign at_end  = (idx_reg + 1'b1) == end_cnt;
    assign busy    = state_reg != S_IDLE;
    assign vidx    = idx_reg[IW-1:0];

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        idx_next   = idx_reg;
        pass_next  = pass_reg;
        dcmd       = '{op: OP_NONE, clear: 1'b0};
        emit       = 1'b0;
        emit_kind  = KIND_ACK;
        emit_last  = 1'b1;
        use_best   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd_next  = cmd;
                    idx_next  = '0;
                    pass_next = 1'b0;
                    dcmd.clear = 1'b1;
                    if (cmd > CMD_TICK || (cmd == CMD_NOTE_ON && !sample_present))
                        state_next = S_OUT;
                    else
                        state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_RD;
                idx_next   = idx_reg + 1'b1;
                case (cmd_reg)
                    CMD_NOTE_ON:
                    begin
                        if (!pass_reg && stat.idle_hit)
                        begin
                            state_next = S_WR;
                        end
                        else
                        begin
                            if (pass_reg)
                                dcmd.op = OP_SCAN;
                            if (at_end)
                            begin
                                if (!pass_reg && (steal_mode == STEAL_OLDEST ||
                                    steal_mode == STEAL_QUIETEST))
                                begin
                                    pass_next = 1'b1;
                                    idx_next  = '0;
                                end
                                else if (pass_reg)
                                begin
                                    state_next = S_WR;
                                end
                                else
                                    state_next = S_OUT;
                            end
                        end
                    end
                    CMD_NOTE_OFF:
                    begin
                        if (stat.note_hit)
                        begin
                            dcmd.op    = OP_RELEASE;
                            state_next = S_OUT;
                        end
                        else if (at_end)
                            state_next = S_OUT;
                    end
                    CMD_ALL_OFF:
                    begin
                        dcmd.op = OP_RELEASE;
                        if (at_end) state_next = S_OUT;
                    end
                    CMD_PANIC:
                    begin
                        dcmd.op = OP_PANIC;
                        if (at_end) state_next = S_OUT;
                    end
                    CMD_TICK:
                    begin
                        // wait for the output register before writing back
                        if (out_free)
                        begin
                            dcmd.op   = OP_TICK;
                            emit      = 1'b1;
                            emit_kind = KIND_REPORT;
                            emit_last = at_end;
                            if (at_end) state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg;
                            state_next = S_EVAL;
                        end
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_WR:
            begin
                // pass 1 uses the best candidate index
                use_best = pass_reg;
                if (out_free)
                begin
                    dcmd.op    = OP_WRITE_ON;
                    emit       = 1'b1;
                    emit_kind  = KIND_NOTE_ON;
                    state_next = S_IDLE;
                end
                else
                    idx_next = idx_reg;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_kind  = (cmd_reg == CMD_NOTE_ON) ? KIND_NOTE_ON : KIND_ACK;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // in S_WR of idle pass the index must stay on the hit voice
        if (state_reg == S_EVAL && state_next == S_WR && !pass_reg)
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '0;
            idx_reg   <= '0;
            pass_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            idx_reg   <= idx_next;
            pass_reg  <= pass_next;
        end
    end
endmodule

[rtl/vaa_dp.sv]
// Voice table datapath: per-voice RAMs, envelope step, steal search.
// Depends on vaa_pkg and vaa_ram.
module vaa_dp import vaa_pkg::*; #(
    parameter int VOICE_COUNT = 32,
    parameter int IW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       dcmd,
    input  logic [IW-1:0] vidx,
    input  logic          use_best,
    input  logic          emit,
    input  logic          fail_out,
    input  logic [6:0]    in_note,
    input  logic [16:0]   in_vel,
    input  logic [1:0]    steal_mode,
    input  logic [16:0]   sustain,
    input  logic [16:0]   attack_step,
    input  logic [16:0]   decay_step,
    input  logic [16:0]   release_step,
    output dp_stat_t      stat,
    output logic [IW-1:0] out_idx,
    output logic [2:0]    out_stage,
    output logic [16:0]   out_level,
    output logic [6:0]    out_note,
    output logic [16:0]   out_vel
);
    // valid bits stand for the reset value of every array
    logic [VOICE_COUNT-1:0] vld_reg;
    logic [31:0]   counter_reg;
    logic [31:0]   best_key_reg;
    logic [IW-1:0] best_idx_reg;
    logic          found_reg;
    logic [6:0]    note_q;
    logic [16:0]   vel_q;

    logic [IW-1:0] addr;
    logic          we;
    logic [2:0]    st_w, st_r;
    logic [16:0]   pg_w, pg_r, lv_w, lv_r, rs_w, rs_r, vl_w, vl_r;
    logic [6:0]    nt_w, nt_r;
    logic [31:0]   ag_w, ag_r;
    logic [2:0]    st_c;
    logic [16:0]   pg_c, lv_c, rs_c, vl_c;
    logic [6:0]    nt_c;
    logic [31:0]   ag_c;
    logic          v_ok;

    assign addr = use_best ? best_idx_reg : vidx;
    assign v_ok = vld_reg[addr];
    assign st_c = v_ok ? st_r : ST_IDLE;
    assign pg_c = v_ok ? pg_r : '0;
    assign lv_c = v_ok ? lv_r : '0;
    assign rs_c = v_ok ? rs_r : '0;
    assign nt_c = v_ok ? nt_r : '0;
    assign vl_c = v_ok ? vl_r : '0;
    assign ag_c = v_ok ? ag_r : '0;

    vaa_ram #(.WIDTH(3),  .DEPTH(VOICE_COUNT)) u_st (.clk, .we, .addr, .wdata(st_w), .rdata(st_r));
    vaa_ram #(.WIDTH(17), .DEPTH(VOICE_COUNT)) u_pg (.clk, .we, .addr, .wdata(pg_w), .rdata(pg_r));
    vaa_ram #(.WIDTH(17), .DEPTH(VOICE_COUNT)) u_lv (.clk, .we, .addr, .wdata(lv_w), .rdata(lv_r));
    vaa_ram #(.WIDTH(17), .DEPTH(VOICE_COUNT)) u_rs (.clk, .we, .addr, .wdata(rs_w), .rdata(rs_r));
    vaa_ram #(.WIDTH(7),  .DEPTH(VOICE_COUNT)) u_nt (.clk, .we, .addr, .wdata(nt_w), .rdata(nt_r));
    vaa_ram #(.WIDTH(17), .DEPTH(VOICE_COUNT)) u_vl (.clk, .we, .addr, .wdata(vl_w), .rdata(vl_r));
    vaa_ram #(.WIDTH(32), .DEPTH(VOICE_COUNT)) u_ag (.clk, .we, .addr, .wdata(ag_w), .rdata(ag_r));

    // envelope advance
    logic [2:0]  adv_st;
    logic [17:0] psum;
    logic [16:0] inc, adv_pg, adv_lv, inv_s, inv_p;
    logic [33:0] prod;
    logic [16:0] sus_s;

    assign sus_s = sat_full(sustain);
    assign inv_s = FULL - sus_s;

    always_comb
    begin
        case (stage_t'(st_c))
            ST_ATTACK:  inc = step_of(attack_step);
            ST_DECAY:   inc = step_of(decay_step);
            default:    inc = step_of(release_step);
        endcase
        psum   = {1'b0, pg_c} + {1'b0, inc};
        adv_st = st_c;
        adv_pg = pg_c;
        case (stage_t'(st_c))
            ST_ATTACK, ST_DECAY, ST_RELEASE:
            begin
                adv_pg = psum[16:0];
                if (psum >= {1'b0, FULL})
                begin
                    if (st_c == ST_RELEASE)
                        adv_st = ST_IDLE;
                    else
                    begin
                        adv_pg = '0;
                        adv_st = (st_c == ST_ATTACK) ? ST_DECAY : ST_SUSTAIN;
                    end
                end
            end
            ST_SUSTAIN: adv_st = ST_SUSTAIN;
            default:    adv_st = ST_IDLE;
        endcase
        // progress stays below 2*FULL; only release can keep an overflowed value
        inv_p = (psum >= {1'b0, FULL}) ? 17'd0 : FULL - adv_pg;
        if (adv_st == ST_DECAY)
            prod = adv_pg * inv_s;
        else
            prod = rs_c * inv_p;
        case (stage_t'(adv_st))
            ST_ATTACK:  adv_lv = adv_pg;
            ST_DECAY:   adv_lv = FULL - prod[32:16];
            ST_SUSTAIN: adv_lv = sus_s;
            ST_RELEASE: adv_lv = prod[32:16];
            default:    adv_lv = '0;
        endcase
    end

    // stored release progress may exceed 17 bits only when leaving to idle
    logic [16:0] adv_pg_store;
    assign adv_pg_store = psum[17] ? psum[16:0] : adv_pg;

    logic [31:0] key;
    assign key = (steal_mode == STEAL_OLDEST) ? ag_c : {15'd0, lv_c};
    logic [31:0] cnt_inc;
    assign cnt_inc = counter_reg + 32'd1;

    assign stat.idle_hit = st_c == ST_IDLE;
    assign stat.note_hit = st_c != ST_IDLE && st_c != ST_RELEASE && nt_c == note_q;

    always_comb
    begin
        we   = 1'b0;
        st_w = st_c; pg_w = pg_c; lv_w = lv_c; rs_w = rs_c;
        nt_w = nt_c; vl_w = vl_c; ag_w = ag_c;
        case (dcmd.op)
            OP_WRITE_ON:
            begin
                we = 1'b1;
                st_w = ST_ATTACK; pg_w = '0; lv_w = '0;
                nt_w = note_q; vl_w = vel_q; ag_w = cnt_inc;
            end
            OP_RELEASE:
            begin
                if (st_c != ST_IDLE && st_c != ST_RELEASE)
                begin
                    we = 1'b1;
                    st_w = ST_RELEASE; pg_w = '0; rs_w = lv_c;
                end
            end
            OP_PANIC:
            begin
                we = 1'b1;
                st_w = ST_IDLE; lv_w = '0; nt_w = '0;
            end
            OP_TICK:
            begin
                we = 1'b1;
                st_w = adv_st; pg_w = adv_pg_store; lv_w = adv_lv;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            counter_reg <= '0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[addr] <= 1'b1;
            if (dcmd.op == OP_WRITE_ON)
                counter_reg <= cnt_inc;
            if (dcmd.clear)
                found_reg <= 1'b0;
            else if (dcmd.op == OP_SCAN)
                found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dcmd.clear)
        begin
            note_q <= in_note;
            vel_q  <= sat_full(in_vel);
        end
        if (dcmd.op == OP_SCAN && (!found_reg || key < best_key_reg))
        begin
            best_key_reg <= key;
            best_idx_reg <= vidx;
        end
        if (emit)
        begin
            if (fail_out)
            begin
                out_idx <= '0; out_stage <= '0; out_level <= '0;
                out_note <= '0; out_vel <= '0;
            end
            else if (dcmd.op == OP_WRITE_ON)
            begin
                out_idx <= addr; out_stage <= ST_ATTACK; out_level <= '0;
                out_note <= note_q; out_vel <= vel_q;
            end
            else
            begin
                out_idx <= addr; out_stage <= adv_st; out_level <= adv_lv;
                out_note <= nt_c; out_vel <= vl_c;
            end
        end
    end
endmodule

[rtl/voice_allocator_adsr.sv]
// Polyphonic voice allocator with ADSR envelopes, Q16; uses vaa_pkg, vaa_ctrl, vaa_dp.
// Note on scans up to limit for an idle voice, then a steal scan if stealing is on;
// note off stops at its first hit; all off and panic walk all VOICE_COUNT voices.
// Tick: one report per voice up to limit; a full output register stalls the walk.
// One request at a time: the sequencer walks voice by voice, a RAM read then an update.
// Reset: async active low; config to defaults, voice table reads idle via valid bits.
module voice_allocator_adsr import vaa_pkg::*; #(
    parameter int VOICE_COUNT = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [6:0]  note,
    input  logic [16:0] velocity,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [4:0]  voice_index,
    output logic        granted,
    output logic [2:0]  stage,
    output logic [16:0] level,
    output logic [6:0]  voice_note,
    output logic [16:0] voice_velocity,
    output logic        last,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    localparam int IW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int MAXV = (VOICE_COUNT < 32) ? VOICE_COUNT : 32;

    logic [5:0]  limit_cfg_reg;
    logic [1:0]  steal_reg;
    logic        sample_reg;
    logic [16:0] sustain_reg, attack_reg, decay_reg, release_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_cfg_reg <= 6'd32;
            steal_reg     <= 2'd0;
            sample_reg    <= 1'b0;
            sustain_reg   <= 17'd45875;
            attack_reg    <= 17'd1365;
            decay_reg     <= 17'd1365;
            release_reg   <= 17'd1365;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LIMIT:   limit_cfg_reg <= cfg_data[5:0];
                REG_STEAL:   steal_reg     <= cfg_data[1:0];
                REG_SAMPLE:  sample_reg    <= cfg_data[0];
                REG_SUSTAIN: sustain_reg   <= cfg_data;
                REG_ATTACK:  attack_reg    <= cfg_data;
                REG_DECAY:   decay_reg     <= cfg_data;
                REG_RELEASE: release_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic [IW:0] limit, all_count;
    always_comb
    begin
        if (limit_cfg_reg == 6'd0)
            limit = (IW+1)'(1);
        else if ({1'b0, limit_cfg_reg} > 7'(MAXV))
            limit = (IW+1)'(MAXV);
        else
            limit = (IW+1)'(limit_cfg_reg);
    end
    assign all_count = (IW+1)'(VOICE_COUNT);

    dp_cmd_t       dcmd;
    dp_stat_t      stat;
    logic          busy, emit, emit_last, use_best, in_fire, out_free;
    logic [1:0]    emit_kind;
    logic [IW-1:0] vidx, o_idx;

    assign in_ready = !busy;
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    vaa_ctrl #(.IW(IW)) u_ctrl (
        .clk, .rst_n, .in_fire, .cmd(command), .limit, .all_count,
        .sample_present(sample_reg), .steal_mode(steal_reg), .stat,
        .out_free, .busy, .dcmd, .vidx, .emit, .emit_kind, .emit_last, .use_best
    );

    logic fail_out;
    assign fail_out = emit && dcmd.op != OP_WRITE_ON && dcmd.op != OP_TICK;

    logic [2:0]  o_stage;
    logic [16:0] o_level, o_vel;
    logic [6:0]  o_note;

    vaa_dp #(.VOICE_COUNT(VOICE_COUNT), .IW(IW)) u_dp (
        .clk, .rst_n, .dcmd, .vidx, .use_best, .emit, .fail_out,
        .in_note(note), .in_vel(velocity), .steal_mode(steal_reg),
        .sustain(sustain_reg), .attack_step(attack_reg), .decay_step(decay_reg),
        .release_step(release_reg), .stat, .out_idx(o_idx),
        .out_stage(o_stage), .out_level(o_level), .out_note(o_note), .out_vel(o_vel)
    );

    logic       valid_reg, granted_reg, last_reg;
    logic [1:0] kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg    <= emit_kind;
            granted_reg <= dcmd.op == OP_WRITE_ON;
            last_reg    <= emit_last;
        end
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign granted        = granted_reg;
    assign last           = last_reg;
    assign voice_index    = 5'(o_idx);
    assign stage          = o_stage;
    assign level          = o_level;
    assign voice_note     = o_note;
    assign voice_velocity = o_vel;
endmodule

[rtl/vaa_checker.sv]
// Port-level checker for the voice allocator, bound to the top level.
// Depends on vaa_pkg and voice_allocator_adsr_macros.svh.
`include "voice_allocator_adsr_macros.svh"
module vaa_checker import vaa_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  kind,
    input logic        granted,
    input logic        last,
    input logic [16:0] level
);
    `VA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `VA_ASSERT_IMPL(a_single_last, clk, rst_n, out_valid && kind != KIND_REPORT, last)
    `VA_ASSERT_IMPL(a_grant_kind, clk, rst_n, out_valid && granted, kind == KIND_NOTE_ON)
    `VA_ASSERT_IMPL(a_level_range, clk, rst_n, out_valid, level <= FULL)
    `VA_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule

bind voice_allocator_adsr vaa_checker u_chk (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .kind, .granted, .last, .level
);

[test/voice_allocator_adsr_tb.sv]
// Testbench for voice_allocator_adsr: random and directed voice commands,
// checked against an in-bench envelope and allocation predictor.
// Depends on vaa_pkg and the voice_allocator_adsr RTL.
module voice_allocator_adsr_tb;
    import vaa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = 32;
    localparam logic [16:0] Q16_FULL = 17'd65536;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [2:0]  command;
        logic [6:0]  note;
        logic [16:0] velocity;
    } request_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  voice_index;
        logic        granted;
        logic [2:0]  stage;
        logic [16:0] level;
        logic [6:0]  voice_note;
        logic [16:0] voice_velocity;
        logic        last;
    } report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] command = '0;
    logic [6:0] note = '0;
    logic [16:0] velocity = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [1:0] kind;
    logic [4:0] voice_index;
    logic granted;
    logic [2:0] stage;
    logic [16:0] level;
    logic [6:0] voice_note;
    logic [16:0] voice_velocity;
    logic last;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;

    voice_allocator_adsr dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // predictor state
    logic [5:0]  voice_limit_reg;
    logic [1:0]  steal_mode_reg;
    logic        sample_loaded;
    logic [16:0] sustain_reg, attack_reg, decay_reg, release_reg;
    stage_t      v_stage [NV];
    logic [31:0] v_progress [NV];
    logic [31:0] v_level [NV];
    logic [31:0] v_rel_start [NV];
    logic [6:0]  v_note [NV];
    logic [16:0] v_vel [NV];
    logic [31:0] v_age [NV];
    logic [31:0] note_count;

    request_t pending_requests[$];
    report_t  expected_reports[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    bit failed = 1'b0;
    bit req_taken = 1'b0;
    longint cycle_count = 0;

    function automatic logic [31:0] clamp_full(input logic [31:0] v);
        return (v > 32'd65536) ? 32'd65536 : v;
    endfunction

    function automatic logic [31:0] step_value(input logic [16:0] v);
        return (v == 0) ? 32'd1 : clamp_full(32'(v));
    endfunction

    function automatic int voice_span();
        int n;
        n = voice_limit_reg;
        if (n == 0) n = 1;
        if (n > NV) n = NV;
        return n;
    endfunction

    function automatic logic [31:0] envelope_level(input int i);
        logic [31:0] s, p;
        logic [63:0] prod;
        s = clamp_full(32'(sustain_reg));
        p = v_progress[i];
        case (v_stage[i])
            ST_ATTACK: return p;
            ST_DECAY:
            begin
                prod = 64'(p) * 64'(32'd65536 - s);
                return 32'd65536 - 32'(prod >> 16);
            end
            ST_SUSTAIN: return s;
            ST_RELEASE:
            begin
                if (p >= 32'd65536) return 0;
                prod = 64'(v_rel_start[i]) * 64'(32'd65536 - p);
                return 32'(prod >> 16);
            end
            default: return 0;
        endcase
    endfunction

    task automatic advance_envelope(input int i);
        stage_t st;
        logic [31:0] inc;
        st = v_stage[i];
        if (st == ST_ATTACK || st == ST_DECAY || st == ST_RELEASE)
        begin
            inc = (st == ST_ATTACK) ? step_value(attack_reg)
                : (st == ST_DECAY) ? step_value(decay_reg) : step_value(release_reg);
            v_progress[i] += inc;
            if (v_progress[i] >= 32'd65536)
            begin
                if (st == ST_RELEASE)
                    v_stage[i] = ST_IDLE;
                else
                begin
                    v_progress[i] = 0;
                    v_stage[i] = (st == ST_ATTACK) ? ST_DECAY : ST_SUSTAIN;
                end
            end
        end
        else if (st != ST_SUSTAIN)
            v_stage[i] = ST_IDLE;
        v_level[i] = envelope_level(i);
    endtask

    task automatic enter_release(input int i);
        if (v_stage[i] != ST_IDLE && v_stage[i] != ST_RELEASE)
        begin
            v_stage[i] = ST_RELEASE;
            v_progress[i] = 0;
            v_rel_start[i] = v_level[i];
        end
    endtask

    function automatic int choose_voice(input int n);
        int idx;
        logic [31:0] best, key;
        idx = -1;
        best = 0;
        for (int i = 0; i < n; i++)
            if (v_stage[i] == ST_IDLE) return i;
        if (steal_mode_reg != STEAL_OLDEST && steal_mode_reg != STEAL_QUIETEST)
            return -1;
        for (int i = 0; i < n; i++)
        begin
            key = (steal_mode_reg == STEAL_OLDEST) ? v_age[i] : v_level[i];
            if (idx < 0 || key < best)
            begin
                best = key;
                idx = i;
            end
        end
        return idx;
    endfunction

    task automatic predict_request(input request_t r);
        int n, v;
        logic [16:0] vel;
        report_t rep;
        n = voice_span();
        vel = 17'(clamp_full(32'(r.velocity)));
        rep = '0;
        rep.last = 1'b1;
        case (r.command)
            CMD_NOTE_ON:
            begin
                v = sample_loaded ? choose_voice(n) : -1;
                rep.kind = KIND_NOTE_ON;
                if (v >= 0)
                begin
                    v_note[v] = r.note;
                    v_vel[v] = vel;
                    v_stage[v] = ST_ATTACK;
                    v_level[v] = 0;
                    v_progress[v] = 0;
                    note_count += 1;
                    v_age[v] = note_count;
                    rep.voice_index = 5'(v);
                    rep.granted = 1'b1;
                    rep.stage = ST_ATTACK;
                    rep.voice_note = r.note;
                    rep.voice_velocity = vel;
                end
                expected_reports.push_back(rep);
            end
            CMD_TICK:
            begin
                for (int i = 0; i < n; i++)
                begin
                    advance_envelope(i);
                    rep.kind = KIND_REPORT;
                    rep.voice_index = 5'(i);
                    rep.granted = 1'b0;
                    rep.stage = v_stage[i];
                    rep.level = 17'(v_level[i]);
                    rep.voice_note = v_note[i];
                    rep.voice_velocity = v_vel[i];
                    rep.last = (i + 1 == n);
                    expected_reports.push_back(rep);
                end
            end
            default:
            begin
                if (r.command == CMD_NOTE_OFF)
                begin
                    for (int i = 0; i < n; i++)
                        if (v_stage[i] != ST_IDLE && v_stage[i] != ST_RELEASE
                            && v_note[i] == r.note)
                        begin
                            enter_release(i);
                            break;
                        end
                end
                else if (r.command == CMD_ALL_OFF)
                    for (int i = 0; i < NV; i++) enter_release(i);
                else if (r.command == CMD_PANIC)
                    for (int i = 0; i < NV; i++)
                    begin
                        v_stage[i] = ST_IDLE;
                        v_level[i] = 0;
                        v_note[i] = 0;
                    end
                rep.kind = KIND_ACK;
                expected_reports.push_back(rep);
            end
        endcase
    endtask

    // driver: an offered request stays until the monitor has seen it taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || req_taken)
            begin
                req_taken = 1'b0;
                if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    command <= pending_requests[0].command;
                    note <= pending_requests[0].note;
                    velocity <= pending_requests[0].velocity;
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // acceptance and monitor
    always @(posedge clk)
    begin
        report_t got, want;
        cycle_count <= cycle_count + 1;
        if (rst_n && in_valid && in_ready)
        begin
            predict_request(pending_requests.pop_front());
            req_taken = 1'b1;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = {kind, voice_index, granted, stage, level, voice_note,
                   voice_velocity, last};
            if (expected_reports.size() == 0)
            begin
                $error("result with nothing expected: kind %0d", kind);
                failed = 1'b1;
            end
            else
            begin
                want = expected_reports.pop_front();
                if (got.kind !== want.kind)
                begin
                    $error("kind: expected %0d got %0d", want.kind, got.kind);
                    failed = 1'b1;
                end
                if (got.voice_index !== want.voice_index)
                begin
                    $error("voice_index: expected %0d got %0d", want.voice_index,
                           got.voice_index);
                    failed = 1'b1;
                end
                if (got.granted !== want.granted)
                begin
                    $error("granted: expected %0d got %0d", want.granted, got.granted);
                    failed = 1'b1;
                end
                if (got.stage !== want.stage)
                begin
                    $error("stage: expected %0d got %0d", want.stage, got.stage);
                    failed = 1'b1;
                end
                if (got.level !== want.level)
                begin
                    $error("level: expected %0d got %0d", want.level, got.level);
                    failed = 1'b1;
                end
                if (got.voice_note !== want.voice_note)
                begin
                    $error("voice_note: expected %0d got %0d", want.voice_note,
                           got.voice_note);
                    failed = 1'b1;
                end
                if (got.voice_velocity !== want.voice_velocity)
                begin
                    $error("voice_velocity: expected %0d got %0d", want.voice_velocity,
                           got.voice_velocity);
                    failed = 1'b1;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d got %0d", want.last, got.last);
                    failed = 1'b1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LIMIT: voice_limit_reg = val[5:0];
            REG_STEAL: steal_mode_reg = val[1:0];
            REG_SAMPLE: sample_loaded = val[0];
            REG_SUSTAIN: sustain_reg = val;
            REG_ATTACK: attack_reg = val;
            REG_DECAY: decay_reg = val;
            default: release_reg = val;
        endcase
    endtask

    task automatic queue_request(input logic [2:0] c, input logic [6:0] n,
                                 input logic [16:0] v);
        request_t r;
        r.command = c;
        r.note = n;
        r.velocity = v;
        pending_requests.push_back(r);
    endtask

    task automatic drain_all();
        wait (pending_requests.size() == 0 && expected_reports.size() == 0);
        // wait out acknowledges still being processed inside the block
        repeat (4 * NV + 10) @(posedge clk);
    endtask

    function automatic logic [16:0] rand_velocity();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return Q16_FULL;
            2: return 17'h1FFFF;
            default: return 17'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [6:0] held [$];
        logic [6:0] nt;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                nt = 7'($urandom);
                held.push_back(nt);
                queue_request(CMD_NOTE_ON, nt, rand_velocity());
            end
            else if (pick < 58)
            begin
                nt = (held.size() > 0 && $urandom_range(3) != 0)
                     ? held[$urandom_range(held.size() - 1)] : 7'($urandom);
                queue_request(CMD_NOTE_OFF, nt, 17'($urandom));
            end
            else if (pick < 90)
                queue_request(CMD_TICK, 7'($urandom), 17'($urandom));
            else if (pick < 94)
                queue_request(CMD_ALL_OFF, 7'($urandom), 17'($urandom));
            else if (pick < 96)
            begin
                queue_request(CMD_PANIC, 7'($urandom), 17'($urandom));
                held.delete();
            end
            else
                queue_request(3'($urandom_range(7, 5)), 7'($urandom), 17'($urandom));
        end
    endtask

    initial
    begin
        voice_limit_reg = 6'd32;
        steal_mode_reg = 2'd0;
        sample_loaded = 1'b0;
        sustain_reg = 17'd45875;
        attack_reg = 17'd1365;
        decay_reg = 17'd1365;
        release_reg = 17'd1365;
        note_count = 0;
        for (int i = 0; i < NV; i++)
        begin
            v_stage[i] = ST_IDLE;
            v_progress[i] = 0;
            v_level[i] = 0;
            v_rel_start[i] = 0;
            v_note[i] = 0;
            v_vel[i] = 0;
            v_age[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: note on with no sample, defaults, then small table with stealing
        queue_request(CMD_NOTE_ON, 7'd60, 17'd1000);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        drain_all();
        write_reg(REG_SAMPLE, 17'd1);
        write_reg(REG_LIMIT, 17'd2);
        write_reg(REG_STEAL, 17'(STEAL_OLDEST));
        write_reg(REG_ATTACK, 17'd65536);
        write_reg(REG_DECAY, 17'd0);
        write_reg(REG_RELEASE, 17'h1FFFF);
        write_reg(REG_SUSTAIN, 17'h1FFFF);
        queue_request(CMD_NOTE_ON, 7'd0, 17'd0);
        queue_request(CMD_NOTE_ON, 7'd127, 17'h1FFFF);
        queue_request(CMD_NOTE_ON, 7'd64, Q16_FULL);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(CMD_NOTE_OFF, 7'd127, 17'd0);
        queue_request(CMD_NOTE_OFF, 7'd99, 17'd0);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(CMD_ALL_OFF, 7'd0, 17'd0);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(3'd5, 7'h55, 17'h0AAAA);
        queue_request(3'd7, 7'h2A, 17'h15555);
        queue_request(CMD_PANIC, 7'd0, 17'd0);
        drain_all();
        write_reg(REG_STEAL, 17'(STEAL_QUIETEST));
        write_reg(REG_LIMIT, 17'd0);
        write_reg(REG_SUSTAIN, 17'd0);
        queue_request(CMD_NOTE_ON, 7'd10, 17'd5);
        queue_request(CMD_NOTE_ON, 7'd11, 17'd6);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        drain_all();
        write_reg(REG_STEAL, 17'd3);
        write_reg(REG_LIMIT, 17'd63);
        queue_request(CMD_NOTE_ON, 7'd20, 17'd7);
        queue_request(CMD_NOTE_ON, 7'd21, 17'd8);
        queue_request(CMD_TICK, 7'd0, 17'd0);
        drain_all();

        // random phases with different settings and handshake pressure
        write_reg(REG_LIMIT, 17'd4);
        write_reg(REG_STEAL, 17'(STEAL_OLDEST));
        write_reg(REG_ATTACK, 17'd20000);
        write_reg(REG_DECAY, 17'd30000);
        write_reg(REG_RELEASE, 17'd25000);
        write_reg(REG_SUSTAIN, 17'd40000);
        random_phase(110);
        drain_all();

        send_idle_pct = 77;
        write_reg(REG_LIMIT, 17'd8);
        write_reg(REG_STEAL, 17'(STEAL_QUIETEST));
        write_reg(REG_ATTACK, 17'd1);
        write_reg(REG_SUSTAIN, 17'd65536);
        random_phase(90);
        drain_all();

        send_idle_pct = 0;
        recv_stall_pct = 77;
        write_reg(REG_LIMIT, 17'd3);
        write_reg(REG_ATTACK, 17'd40000);
        write_reg(REG_RELEASE, 17'd1);
        write_reg(REG_SUSTAIN, 17'd12345);
        random_phase(90);
        drain_all();

        send_idle_pct = 36;
        recv_stall_pct = 36;
        write_reg(REG_LIMIT, 17'd32);
        write_reg(REG_STEAL, 17'(STEAL_OLDEST));
        write_reg(REG_RELEASE, 17'd9000);
        write_reg(REG_SAMPLE, 17'd0);
        random_phase(25);
        drain_all();
        write_reg(REG_SAMPLE, 17'd1);
        write_reg(REG_LIMIT, 17'd5);
        random_phase(90);

        // long receiver hold-off while requests keep coming
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        random_phase(40);
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
        drain_all();

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[sim.f]
+incdir+rtl
rtl/vaa_pkg.sv
rtl/vaa_ram.sv
rtl/vaa_ctrl.sv
rtl/vaa_dp.sv
rtl/voice_allocator_adsr.sv
rtl/vaa_checker.sv
test/voice_allocator_adsr_tb.sv
